### rtl/core/frd_pkg.sv
// Shared constants and controller/datapath handshake types for the fraction difference block.
package frd_pkg;

  // Default operand width of the input fields.
  localparam int OPERAND_WIDTH_DEF = 16;

  // Operand pairing for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_NA_DB = 2'd0,
    MUL_NB_DA = 2'd1,
    MUL_DA_DB = 2'd2
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     diff_en;
    logic     gcd_init;
    logic     gcd_step;
    logic     div_init;
    logic     div_step;
    logic     load_out;
  } frd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic den_zero;
    logic num_zero;
    logic gcd_done;
    logic div_done;
  } frd_status_t;

endpackage

### rtl/core/frd_in_if.sv
// Input request channel carrying the two fractions.
interface frd_in_if
  import frd_pkg::*;
#(
  parameter int W = OPERAND_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] num_a;
  logic signed [W-1:0] den_a;
  logic signed [W-1:0] num_b;
  logic signed [W-1:0] den_b;

  modport source (output valid, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, num_a, den_a, num_b, den_b, output ready);
endinterface

### rtl/core/frd_out_if.sv
// Result channel carrying the reduced difference and the error flag.
interface frd_out_if
  import frd_pkg::*;
#(
  parameter int W = OPERAND_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic signed [2*W:0]   diff_num;
  logic signed [2*W-1:0] diff_den;
  logic                  zero_den_error;

  modport source (output valid, diff_num, diff_den, zero_den_error, input ready);
  modport sink   (input valid, diff_num, diff_den, zero_den_error, output ready);
endinterface

### rtl/core/frd_ctrl.sv
// Sequencing state machine for the fraction difference block.
module frd_ctrl
  import frd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  frd_status_t status,
  output frd_cmd_t    cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_MUL1   = 8'b0000_0010,
    ST_MUL2   = 8'b0000_0100,
    ST_MUL3   = 8'b0000_1000,
    ST_SETUP  = 8'b0001_0000,
    ST_GCD    = 8'b0010_0000,
    ST_DIV    = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_MUL1;
        end
      end
      ST_MUL1: begin
        if (status.den_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_NA_DB;
          state_nxt   = ST_MUL2;
        end
      end
      ST_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_NB_DA;
        state_nxt   = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DA_DB;
        cmd.diff_en = 1'b1;
        state_nxt   = ST_SETUP;
      end
      ST_SETUP: begin
        if (status.num_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.gcd_init = 1'b1;
          state_nxt    = ST_GCD;
        end
      end
      ST_GCD: begin
        if (status.gcd_done) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/frd_datapath.sv
// Multiplier, binary gcd unit, dual restoring divider and result register.
module frd_datapath
  import frd_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)(
  input  logic                            clk,
  input  logic signed [OPERAND_WIDTH-1:0] num_a,
  input  logic signed [OPERAND_WIDTH-1:0] den_a,
  input  logic signed [OPERAND_WIDTH-1:0] num_b,
  input  logic signed [OPERAND_WIDTH-1:0] den_b,
  input  frd_cmd_t                        cmd,
  output frd_status_t                     status,
  output logic signed [2*OPERAND_WIDTH:0]   diff_num,
  output logic signed [2*OPERAND_WIDTH-1:0] diff_den,
  output logic                            zero_den_error
);

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int N  = 2 * W + 1;
  localparam int KW = $clog2(N + 1);

  // Latched operands.
  logic signed [W-1:0] na_r, da_r, nb_r, db_r;
  logic                err_r;

  // Products and raw difference.
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic [PW-1:0]        p_a_r, p_b_r, dd_r;
  logic [N-1:0]         nn_r;
  logic                 neg_n_r, neg_d_r;

  // GCD and divider state.
  logic [N-1:0]  a_r, b_r, dvs_r;
  logic [KW-1:0] k_r, cnt_r;
  logic [N-1:0]  qn_r, rn_r, qd_r, rd_r;

  // Result register.
  logic [N-1:0]  diff_num_r;
  logic [PW-1:0] diff_den_r;
  logic          zde_r;

  logic [N-1:0]  mag_n;
  logic [PW-1:0] mag_d_w;
  logic [N:0]    trial_n, trial_d;
  logic          ge_n, ge_d;
  logic [N-1:0]  res_n;
  logic [PW-1:0] res_d;

  always_comb begin
    case (cmd.mul_sel)
      MUL_NA_DB: begin
        mul_a = na_r;
        mul_b = db_r;
      end
      MUL_NB_DA: begin
        mul_a = nb_r;
        mul_b = da_r;
      end
      default: begin
        mul_a = da_r;
        mul_b = db_r;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign mag_n   = nn_r[N-1] ? (~nn_r + N'(1)) : nn_r;
  assign mag_d_w = dd_r[PW-1] ? (~dd_r + PW'(1)) : dd_r;

  assign trial_n = {rn_r, qn_r[N-1]};
  assign trial_d = {rd_r, qd_r[N-1]};
  assign ge_n    = (trial_n >= {1'b0, dvs_r});
  assign ge_d    = (trial_d >= {1'b0, dvs_r});

  assign res_n = neg_n_r ? (~qn_r + N'(1)) : qn_r;
  assign res_d = neg_d_r ? (~qd_r[PW-1:0] + PW'(1)) : qd_r[PW-1:0];

  assign status.den_zero = err_r;
  assign status.num_zero = (nn_r == '0);
  assign status.gcd_done = (a_r == '0) || (b_r == '0);
  assign status.div_done = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      na_r  <= num_a;
      da_r  <= den_a;
      nb_r  <= num_b;
      db_r  <= den_b;
      err_r <= (den_a == '0) || (den_b == '0);
    end

    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MUL_NA_DB: p_a_r <= prod;
        MUL_NB_DA: p_b_r <= prod;
        default:   dd_r  <= prod;
      endcase
    end

    if (cmd.diff_en) begin
      nn_r <= {p_a_r[PW-1], p_a_r} - {p_b_r[PW-1], p_b_r};
    end

    if (cmd.gcd_init) begin
      a_r     <= mag_n;
      b_r     <= {1'b0, mag_d_w};
      k_r     <= '0;
      qn_r    <= mag_n;
      qd_r    <= {1'b0, mag_d_w};
      neg_n_r <= nn_r[N-1];
      neg_d_r <= dd_r[PW-1];
    end else if (cmd.gcd_step) begin
      // Binary gcd: strip common factors of two, then shrink the larger odd value.
      if (!a_r[0] && !b_r[0]) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + KW'(1);
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (a_r >= b_r) begin
        a_r <= (a_r - b_r) >> 1;
      end else begin
        b_r <= (b_r - a_r) >> 1;
      end
    end

    if (cmd.div_init) begin
      dvs_r <= (a_r | b_r) << k_r;
      rn_r  <= '0;
      rd_r  <= '0;
      cnt_r <= KW'(N);
    end else if (cmd.div_step) begin
      rn_r  <= ge_n ? trial_n[N-1:0] - dvs_r : trial_n[N-1:0];
      rd_r  <= ge_d ? trial_d[N-1:0] - dvs_r : trial_d[N-1:0];
      qn_r  <= {qn_r[N-2:0], ge_n};
      qd_r  <= {qd_r[N-2:0], ge_d};
      cnt_r <= cnt_r - KW'(1);
    end

    if (cmd.load_out) begin
      if (err_r) begin
        diff_num_r <= '0;
        diff_den_r <= '0;
        zde_r      <= 1'b1;
      end else if (nn_r == '0) begin
        diff_num_r <= '0;
        diff_den_r <= PW'(1);
        zde_r      <= 1'b0;
      end else begin
        diff_num_r <= res_n;
        diff_den_r <= res_d;
        zde_r      <= 1'b0;
      end
    end
  end

  assign diff_num       = diff_num_r;
  assign diff_den       = diff_den_r;
  assign zero_den_error = zde_r;

endmodule

### rtl/core/fraction_difference_reduce.sv
// Top level of the fraction difference block: controller, datapath and channel hookup.
//
// Each input request carries two signed fractions num_a/den_a and num_b/den_b. The block
// returns one result request per input with num_a/den_a - num_b/den_b in lowest terms:
// diff_num carries the sign of the raw numerator, diff_den the sign of den_a*den_b.
// A zero raw numerator gives 0/1. A zero input denominator raises zero_den_error with
// diff_num and diff_den both 0.
// Both channels use a valid/ready handshake; a request moves when both are high.
// One item is in work at a time; a new request is taken only once the controller is
// back in its idle state. The time from acceptance to a valid result is set by the
// binary gcd loop, which runs until one value reaches zero, and the bit-serial divider.
// The error and zero-numerator cases skip the gcd and divide and finish early.
// After reset (synchronous, active low) the block is idle with no result pending.
// The result sits in an output register; while the receiver stalls it holds there and the
// block still accepts and computes the next item, waiting only to hand that one over.
module fraction_difference_reduce
  import frd_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)(
  input  logic       clk,
  input  logic       rst_n,
  frd_in_if.sink     in_chan,
  frd_out_if.source  out_chan
);

  frd_cmd_t    cmd;
  frd_status_t status;

  // The controller owns the handshake and the order of datapath operations.
  frd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the operands, the shared multiplier, the gcd unit,
  // the two-lane divider and the result register.
  frd_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .num_a          (in_chan.num_a),
    .den_a          (in_chan.den_a),
    .num_b          (in_chan.num_b),
    .den_b          (in_chan.den_b),
    .cmd            (cmd),
    .status         (status),
    .diff_num       (out_chan.diff_num),
    .diff_den       (out_chan.diff_den),
    .zero_den_error (out_chan.zero_den_error)
  );

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the fraction difference block: directed table plus random requests.
`timescale 1ns / 100ps

module tb_top
  import frd_pkg::*;
();

  localparam int W = OPERAND_WIDTH_DEF;
  localparam int NUM_W = 2 * W + 1;
  localparam int DEN_W = 2 * W;

  // Number of random requests after the directed table.
  localparam int RANDOM_COUNT = 1500;
  // Requests in this index window go out with no idling on either side.
  localparam int STEADY_FIRST = 600;
  localparam int STEADY_LAST = 800;
  // The receiver holds off once, after this many results, for this many cycles.
  localparam int HOLDOFF_AFTER = 300;
  localparam int HOLDOFF_CYCLES = 400;
  // Cycles to watch for stray results after the last owed one, past the worst-case latency.
  localparam int SETTLE_CYCLES = 150;
  localparam int NUM_ROWS = 21;

  // One input request: the two fractions as raw field bits.
  typedef struct packed {
    logic [W-1:0] num_a;
    logic [W-1:0] den_a;
    logic [W-1:0] num_b;
    logic [W-1:0] den_b;
  } frac_pair_t;

  // One result request: reduced numerator, denominator and the error flag.
  typedef struct packed {
    logic [2*W:0]   diff_num;
    logic [2*W-1:0] diff_den;
    logic           zero_den_error;
  } reduced_diff_t;

  // A directed row: the request, and a typed-in answer when has_answer is set.
  typedef struct packed {
    frac_pair_t    pair;
    logic          has_answer;
    reduced_diff_t answer;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n;

  frd_in_if  #(.W(W)) in_chan();
  frd_out_if #(.W(W)) out_chan();

  fraction_difference_reduce #(.OPERAND_WIDTH(W)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // The 12 ns clock.
  always #6 clk = ~clk;

  // Results still owed by the block, oldest first.
  reduced_diff_t pending_diffs[$];
  int mismatches = 0;
  int results_seen = 0;
  // Set while the sender is inside the steady window; the receiver follows it.
  bit steady = 1'b0;
  table_row_t rows [NUM_ROWS];

  // Computes num_a/den_a - num_b/den_b in lowest terms, the way the block must.
  // The raw numerator needs 33 bits and the raw denominator 32, so 64-bit integers
  // hold everything exactly.
  function automatic reduced_diff_t reduce_difference(frac_pair_t p);
    longint na, da, nb, db;
    longint raw_num, raw_den, mag_num, mag_den;
    longint ga, gb, gt;
    reduced_diff_t r;
    na = $signed(p.num_a);
    da = $signed(p.den_a);
    nb = $signed(p.num_b);
    db = $signed(p.den_b);
    r = '0;
    if (da == 0 || db == 0) begin
      // A zero denominator flags an error and forces both fields to zero.
      r.zero_den_error = 1'b1;
      return r;
    end
    raw_den = da * db;
    raw_num = db * na - da * nb;
    if (raw_num == 0) begin
      // Zero difference is always reported as 0/1, whatever the denominators.
      r.diff_den = DEN_W'(1);
      return r;
    end
    mag_num = (raw_num < 0) ? -raw_num : raw_num;
    mag_den = (raw_den < 0) ? -raw_den : raw_den;
    ga = mag_num;
    gb = mag_den;
    while (gb != 0) begin
      gt = ga % gb;
      ga = gb;
      gb = gt;
    end
    mag_num = mag_num / ga;
    mag_den = mag_den / ga;
    // Each field keeps its own sign: the denominator takes the sign of da*db.
    r.diff_num = NUM_W'((raw_num < 0) ? -mag_num : mag_num);
    r.diff_den = DEN_W'((raw_den < 0) ? -mag_den : mag_den);
    return r;
  endfunction

  // Draws a random request. Most are shaped to hit reduction, zero differences
  // and zero denominators often; the rest use the full field range.
  function automatic frac_pair_t random_pair();
    frac_pair_t p;
    int pick, n, d, k, f;
    pick = $urandom_range(99);
    if (pick < 40) begin
      p = {$urandom, $urandom};
    end else if (pick < 60) begin
      // Small values reduce a lot and hit many sign combinations.
      p.num_a = W'($urandom_range(80) - 40);
      p.den_a = W'($urandom_range(80) - 40);
      p.num_b = W'($urandom_range(80) - 40);
      p.den_b = W'($urandom_range(80) - 40);
    end else if (pick < 72) begin
      // The same fraction scaled by k, so the difference is exactly zero.
      n = $urandom_range(300) - 150;
      d = $urandom_range(149) + 1;
      if ($urandom_range(1)) d = -d;
      k = $urandom_range(49) + 1;
      if ($urandom_range(1)) k = -k;
      p.num_a = W'(n);
      p.den_a = W'(d);
      p.num_b = W'(n * k);
      p.den_b = W'(d * k);
    end else if (pick < 80) begin
      // One or both denominators zero, everything else random.
      p = {$urandom, $urandom};
      case ($urandom_range(2))
        0: p.den_a = '0;
        1: p.den_b = '0;
        default: begin
          p.den_a = '0;
          p.den_b = '0;
        end
      endcase
    end else begin
      // A shared factor in every field gives a large gcd.
      f = $urandom_range(198) + 2;
      p.num_a = W'(f * ($urandom_range(300) - 150));
      p.den_a = W'(f * ($urandom_range(300) - 150));
      p.num_b = W'(f * ($urandom_range(300) - 150));
      p.den_b = W'(f * ($urandom_range(300) - 150));
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what, input reduced_diff_t want,
                                 input reduced_diff_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch: %s expected %0d/%0d err=%0b, got %0d/%0d err=%0b", $realtime,
               what, $signed(want.diff_num), $signed(want.diff_den), want.zero_den_error,
               $signed(got.diff_num), $signed(got.diff_den), got.zero_den_error);
    end
  endtask

  // Offers one request. Called and left at a falling edge, so valid gets one
  // assignment per time step even when back-to-back requests keep it high.
  task automatic offer_request(input frac_pair_t p, input bit has_answer,
                               input reduced_diff_t answer, input int index);
    steady = (index >= STEADY_FIRST && index < STEADY_LAST);
    while (!steady && $urandom_range(99) < 23) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.num_a <= p.num_a;
    in_chan.den_a <= p.den_a;
    in_chan.num_b <= p.num_b;
    in_chan.den_b <= p.den_b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    // The request moved at this edge; record what it must produce.
    pending_diffs.push_back(has_answer ? answer : reduce_difference(p));
    @(negedge clk);
  endtask

  // Stimulus and end of run.
  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.num_a = '0;
    in_chan.den_a = '0;
    in_chan.num_b = '0;
    in_chan.den_b = '0;

    // Directed table. Answers are typed in where they are obvious: error cases,
    // zero differences, whole numbers and tiny fractions. The rest go through
    // the predictor.
    rows = '{
      '{'{16'sd1, 16'sd1, 16'sd1, 16'sd1}, 1'b1, '{33'sd0, 32'sd1, 1'b0}},
      '{'{16'sd5, 16'sd0, 16'sd1, 16'sd1}, 1'b1, '{33'sd0, 32'sd0, 1'b1}},
      '{'{16'sd1, 16'sd1, 16'sd3, 16'sd0}, 1'b1, '{33'sd0, 32'sd0, 1'b1}},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{33'sd0, 32'sd0, 1'b1}},
      '{'{-16'sd32768, 16'sd0, 16'sd32767, -16'sd32768}, 1'b1, '{33'sd0, 32'sd0, 1'b1}},
      '{'{16'sd0, 16'sd1, 16'sd0, 16'sd1}, 1'b1, '{33'sd0, 32'sd1, 1'b0}},
      '{'{16'sd1, 16'sd1, 16'sd0, 16'sd1}, 1'b1, '{33'sd1, 32'sd1, 1'b0}},
      '{'{16'sd0, 16'sd1, 16'sd1, 16'sd1}, 1'b1, '{-33'sd1, 32'sd1, 1'b0}},
      '{'{16'sd1, -16'sd1, 16'sd0, 16'sd1}, 1'b1, '{33'sd1, -32'sd1, 1'b0}},
      '{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767}, 1'b1, '{33'sd0, 32'sd1, 1'b0}},
      '{'{16'sd32767, 16'sd1, -16'sd32768, 16'sd1}, 1'b1, '{33'sd65535, 32'sd1, 1'b0}},
      '{'{-16'sd32768, 16'sd1, 16'sd32767, 16'sd1}, 1'b1, '{-33'sd65535, 32'sd1, 1'b0}},
      '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b1, '{33'sd0, 32'sd1, 1'b0}},
      '{'{16'sd1, 16'sd2, 16'sd1, 16'sd3}, 1'b1, '{33'sd1, 32'sd6, 1'b0}},
      '{'{16'sd2, 16'sd4, 16'sd1, 16'sd4}, 1'b1, '{33'sd1, 32'sd4, 1'b0}},
      '{'{16'sd6, -16'sd4, 16'sd0, 16'sd1}, 1'b1, '{33'sd3, -32'sd2, 1'b0}},
      '{'{-16'sd6, 16'sd4, 16'sd0, -16'sd1}, 1'b1, '{33'sd3, -32'sd2, 1'b0}},
      '{'{-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767}, 1'b0, '0},
      '{'{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767}, 1'b0, '0},
      '{'{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768}, 1'b0, '0},
      '{'{16'h5555, 16'h2AAA, 16'hAAAA, 16'h7FFF}, 1'b0, '0}
    };

    // Hold synchronous reset, then release it at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      offer_request(rows[i].pair, rows[i].has_answer, rows[i].answer, -1);
    end
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      offer_request(random_pair(), 1'b0, '0, i);
    end
    steady = 1'b0;
    in_chan.valid <= 1'b0;

    // Drain: every accepted request must come back, then watch for strays.
    while (pending_diffs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_diffs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Receiver. Ready changes at falling edges; once during the run it stays low
  // for a long stretch while the sender keeps offering, so the block backs up.
  initial begin : receiver
    bit held_off;
    held_off = 1'b0;
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= HOLDOFF_AFTER) begin
        held_off = 1'b1;
        out_chan.ready <= 1'b0;
        for (int c = 0; c < HOLDOFF_CYCLES; c++) @(negedge clk);
      end
      out_chan.ready <= steady || ($urandom_range(99) >= 23);
    end
  end

  // Result checker. Every result request is matched against the oldest owed result.
  always @(posedge clk) begin : result_check
    reduced_diff_t got;
    reduced_diff_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.diff_num = out_chan.diff_num;
      got.diff_den = out_chan.diff_den;
      got.zero_den_error = out_chan.zero_den_error;
      results_seen++;
      if (pending_diffs.size() == 0) begin
        report_mismatch("unexpected result;", '0, got);
      end else begin
        want = pending_diffs.pop_front();
        if (got.diff_num !== want.diff_num || got.diff_den !== want.diff_den ||
            got.zero_den_error !== want.zero_den_error) begin
          report_mismatch("result", want, got);
        end
      end
    end
  end

  // Hard limit on run time, far beyond the slowest correct run.
  initial begin : watchdog
    #12_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### fraction_difference_reduce.f
rtl/core/frd_pkg.sv
rtl/core/frd_in_if.sv
rtl/core/frd_out_if.sv
rtl/core/frd_ctrl.sv
rtl/core/frd_datapath.sv
rtl/core/fraction_difference_reduce.sv
tb/sv/tb_top.sv
